// File: src/hmt_pkg.sv
// Shared constants for the homogeneous matrix transform pipeline.
package hmt_pkg;

    // Item kinds carried in the action field
    localparam logic [1:0] ACT_POINT  = 2'd0;
    localparam logic [1:0] ACT_VECTOR = 2'd1;
    localparam logic [1:0] ACT_NORMAL = 2'd2;

    // Coordinate and coefficient formats
    localparam int COORD_IO_W = 32;
    localparam int LANE_W     = 16;
    localparam int ROW_W      = 4 * LANE_W;
    localparam int ROUND_SH   = 12;
    localparam int ROUND_HALF = 2048;
    localparam int ONE_Q16    = 65536;

    // Rounded dot products and the divider datapath
    localparam int NUM_W      = 40;
    localparam int FRAC_SHIFT = 17;
    localparam int DIV_STEPS  = 2 * FRAC_SHIFT;
    localparam int DIV_RW     = NUM_W + 1;

endpackage

// File: src/hmt_dot.sv
// Four-term dot product: registered products, then registered sum rounded to Q24.16.
module hmt_dot
    import hmt_pkg::*;
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [3:0][COORD_IO_W-1:0]           vec,
    input  logic [3:0][COEF_WIDTH-1:0]           coef,
    output logic signed [NUM_W-1:0]              num
);

    localparam int PROD_W = COORD_IO_W + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [PROD_W-1:0] prod_reg  [4];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [NUM_W-1:0]  num_reg;

    // Multiply each term
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = $signed(vec[k]) * $signed(coef[k]);
        end
    end

    // Sum exactly and round half up to 16 fraction bits
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
            + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        rnd = (sum + $signed(SUM_W'(ROUND_HALF))) >>> ROUND_SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            num_reg <= NUM_W'(rnd);
        end
    end

    assign num = num_reg;

endmodule

// File: src/hmt_div_lane.sv
// Pipelined restoring divider: one quotient bit per stage, Q = floor(un * 2^17 / ud).
module hmt_div_lane
    import hmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [DIV_RW-1:0]      rem_in,
    input  logic [NUM_W-1:0]       den_in,
    input  logic [FRAC_SHIFT-1:0]  bits_in,
    output logic [DIV_STEPS-1:0]   quot
);

    logic [DIV_RW-1:0]     rem_reg   [DIV_STEPS];
    logic [NUM_W-1:0]      den_reg   [DIV_STEPS];
    logic [FRAC_SHIFT-1:0] bits_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0]  quot_reg  [DIV_STEPS];

    logic [DIV_RW-1:0]     rem_cur   [DIV_STEPS];
    logic [NUM_W-1:0]      den_cur   [DIV_STEPS];
    logic [FRAC_SHIFT-1:0] bits_cur  [DIV_STEPS];
    logic [DIV_STEPS-1:0]  quot_cur  [DIV_STEPS];
    logic [DIV_RW-1:0]     trial     [DIV_STEPS];
    logic [DIV_RW-1:0]     rem_next  [DIV_STEPS];
    logic [FRAC_SHIFT-1:0] bits_next [DIV_STEPS];
    logic [DIV_STEPS-1:0]  quot_next [DIV_STEPS];

    // Shift in one dividend bit and subtract the divisor where it fits
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_cur[k]  = rem_in;
                den_cur[k]  = den_in;
                bits_cur[k] = bits_in;
                quot_cur[k] = '0;
            end
            else
            begin
                rem_cur[k]  = rem_reg[k-1];
                den_cur[k]  = den_reg[k-1];
                bits_cur[k] = bits_reg[k-1];
                quot_cur[k] = quot_reg[k-1];
            end
            trial[k]     = {rem_cur[k][DIV_RW-2:0], bits_cur[k][FRAC_SHIFT-1]};
            bits_next[k] = {bits_cur[k][FRAC_SHIFT-2:0], 1'b0};
            if (trial[k] >= {1'b0, den_cur[k]})
            begin
                rem_next[k]  = trial[k] - {1'b0, den_cur[k]};
                quot_next[k] = {quot_cur[k][DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial[k];
                quot_next[k] = {quot_cur[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_cur[k];
                bits_reg[k] <= bits_next[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    assign quot = quot_reg[DIV_STEPS-1];

endmodule

// File: src/homogeneous_matrix_transform_core.sv
// Pipeline depth is set by the 34-stage point divider, one quotient bit per stage.
// Throughput: one transaction per clock; the whole pipeline advances together
// and holds while the output register is full and m_axis_tready is low.
// Reset (rst_n low, asynchronous) empties the pipeline and loads both matrices
// with the identity.
module homogeneous_matrix_transform_core
    import hmt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [ROW_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [95:0]            s_axis_tdata,   // x_in, y_in, z_in
    input  logic [2:0]             s_axis_tuser,   // action[1:0], undo
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [95:0]            m_axis_tdata,   // x_out, y_out, z_out
    output logic [1:0]             m_axis_tuser    // overflow, zero_w
);

    localparam int SAT_W = (COORD_WIDTH < COORD_IO_W) ? COORD_WIDTH : COORD_IO_W;
    localparam logic [DIV_STEPS-1:0] LIM_POS = (DIV_STEPS'(1) << (SAT_W - 1)) - 1'b1;
    localparam logic [DIV_STEPS-1:0] LIM_NEG = DIV_STEPS'(1) << (SAT_W - 1);
    localparam logic [DIV_STEPS-1:0] THR_POS = (LIM_POS >> 16) + 1'b1;
    localparam logic [DIV_STEPS-1:0] THR_NEG = (LIM_NEG >> 16) + 1'b1;
    localparam logic signed [NUM_W-1:0] NUM_POS = $signed(NUM_W'(LIM_POS));
    localparam logic signed [NUM_W-1:0] NUM_NEG = -$signed(NUM_W'(LIM_NEG));
    localparam logic [2:0] CFG_INV_BASE = 3'd4;
    localparam logic [LANE_W-1:0] ONE_COEF = 16'h1000;

    typedef struct packed {
        logic                            is_div;
        logic                            zw;
        logic                            ov;
        logic [2:0]                      neg;
        logic [2:0]                      big;
        logic [2:0][COORD_IO_W-1:0]      res;
    } info_t;

    // Configuration registers
    logic [3:0][ROW_W-1:0] fwd_reg;
    logic [3:0][ROW_W-1:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                fwd_reg[r] <= ROW_W'(ONE_COEF) << (LANE_W * r);
                inv_reg[r] <= ROW_W'(ONE_COEF) << (LANE_W * r);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index < CFG_INV_BASE)
            begin
                fwd_reg[cfg_index[1:0]] <= cfg_data;
            end
            else
            begin
                inv_reg[cfg_index[1:0]] <= cfg_data;
            end
        end
    end

    // Global advance: move everything while the output register can take a result
    logic adv;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: pick coefficients for each row
    logic [1:0]            act;
    logic [3:0][ROW_W-1:0] fm;
    logic [3:0][ROW_W-1:0] im;
    logic [3:0][COORD_IO_W-1:0] vec_next;
    logic [3:0][3:0][COEF_WIDTH-1:0] coef_next;

    always_comb
    begin
        act = s_axis_tuser[1:0];
        fm  = s_axis_tuser[2] ? inv_reg : fwd_reg;
        im  = s_axis_tuser[2] ? fwd_reg : inv_reg;
        vec_next[0] = s_axis_tdata[31:0];
        vec_next[1] = s_axis_tdata[63:32];
        vec_next[2] = s_axis_tdata[95:64];
        vec_next[3] = (act == ACT_POINT) ? COORD_IO_W'(ONE_Q16) : '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (act == ACT_NORMAL)
                begin
                    coef_next[i][j] = (j < 3) ? im[j][LANE_W*i +: COEF_WIDTH] : '0;
                end
                else
                begin
                    coef_next[i][j] = fm[i][LANE_W*j +: COEF_WIDTH];
                end
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            coef_next[3][j] = fm[3][LANE_W*j +: COEF_WIDTH];
        end
    end

    logic [3:0][COORD_IO_W-1:0]      vec_reg;
    logic [3:0][3:0][COEF_WIDTH-1:0] coef_reg;
    logic                            pt1_reg;
    logic                            pt2_reg;
    logic                            pt3_reg;
    logic                            v1_reg;
    logic                            v2_reg;
    logic                            v3_reg;
    logic                            v4_reg;
    logic [DIV_STEPS-1:0]            vd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            coef_reg <= coef_next;
            pt1_reg  <= (act == ACT_POINT);
            pt2_reg  <= pt1_reg;
            pt3_reg  <= pt2_reg;
        end
    end

    // Stages 2 and 3: dot products for x, y, z and w
    logic signed [NUM_W-1:0] num [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_row
        hmt_dot #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_dot (
            .clk  (clk),
            .en   (adv),
            .vec  (vec_reg),
            .coef (coef_reg[g]),
            .num  (num[g])
        );
    end

    // Stage 4: classify w, saturate the direct results, set up the dividers
    info_t                 info_next;
    logic                  w_zero;
    logic                  w_one;
    logic [NUM_W-1:0]      ud;
    logic [NUM_W-1:0]      un   [3];
    logic [DIV_RW-1:0]     r0   [3];
    logic [COORD_IO_W-1:0] satv [3];
    logic [2:0]            sato;

    always_comb
    begin
        w_zero = (num[3] == '0);
        w_one  = (num[3] == $signed(NUM_W'(ONE_Q16)));
        ud     = num[3][NUM_W-1] ? NUM_W'(-num[3]) : NUM_W'(num[3]);
        info_next.is_div = pt3_reg && !w_zero && !w_one;
        info_next.zw     = pt3_reg && w_zero;
        for (int i = 0; i < 3; i++)
        begin
            un[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
            r0[i] = DIV_RW'(un[i] >> FRAC_SHIFT);
            info_next.neg[i] = num[i][NUM_W-1] ^ num[3][NUM_W-1];
            info_next.big[i] = (un[i] >> FRAC_SHIFT) >= ud;
            sato[i] = 1'b0;
            if (num[i] > NUM_POS)
            begin
                satv[i] = COORD_IO_W'(NUM_POS);
                sato[i] = 1'b1;
            end
            else if (num[i] < NUM_NEG)
            begin
                satv[i] = COORD_IO_W'(NUM_NEG);
                sato[i] = 1'b1;
            end
            else
            begin
                satv[i] = COORD_IO_W'(num[i]);
            end
            if (info_next.zw)
            begin
                info_next.res[i] = num[i][NUM_W-1] ? COORD_IO_W'(NUM_NEG)
                                                   : COORD_IO_W'(NUM_POS);
            end
            else
            begin
                info_next.res[i] = satv[i];
            end
        end
        info_next.ov = info_next.zw || (|sato);
    end

    info_t                 info4_reg;
    logic [DIV_RW-1:0]     r0_reg   [3];
    logic [NUM_W-1:0]      ud_reg;
    logic [FRAC_SHIFT-1:0] dbits_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info4_reg <= info_next;
            ud_reg    <= ud;
            for (int i = 0; i < 3; i++)
            begin
                r0_reg[i]    <= r0[i];
                dbits_reg[i] <= un[i][FRAC_SHIFT-1:0];
            end
        end
    end

    // Divider stages, side information travels alongside
    logic [DIV_STEPS-1:0] quot [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        hmt_div_lane u_div (
            .clk     (clk),
            .en      (adv),
            .rem_in  (r0_reg[g]),
            .den_in  (ud_reg),
            .bits_in (dbits_reg[g]),
            .quot    (quot[g])
        );
    end

    info_t info_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0] <= info4_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                info_reg[k] <= info_reg[k-1];
            end
        end
    end

    // Final stage: round the quotient, clamp, apply sign
    info_t                 fin;
    logic [DIV_STEPS-1:0]  lim  [3];
    logic [DIV_STEPS-1:0]  thr  [3];
    logic [DIV_STEPS-1:0]  mag  [3];
    logic [2:0]            dov;
    logic [2:0][COORD_IO_W-1:0] res_final;
    logic                  ov_final;

    always_comb
    begin
        fin = info_reg[DIV_STEPS-1];
        for (int i = 0; i < 3; i++)
        begin
            lim[i] = fin.neg[i] ? LIM_NEG : LIM_POS;
            thr[i] = fin.neg[i] ? THR_NEG : THR_POS;
            dov[i] = 1'b0;
            if (fin.big[i] || ((quot[i] >> FRAC_SHIFT) > thr[i]))
            begin
                dov[i] = 1'b1;
                mag[i] = lim[i];
            end
            else
            begin
                mag[i] = DIV_STEPS'(({1'b0, quot[i]} + 1'b1) >> 1);
                if (mag[i] > lim[i])
                begin
                    dov[i] = 1'b1;
                    mag[i] = lim[i];
                end
            end
            if (fin.is_div)
            begin
                res_final[i] = fin.neg[i] ? COORD_IO_W'(-mag[i]) : COORD_IO_W'(mag[i]);
            end
            else
            begin
                res_final[i] = fin.res[i];
            end
        end
        ov_final = fin.is_div ? (|dov) : fin.ov;
    end

    logic [95:0] tdata_reg;
    logic [1:0]  tuser_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= {res_final[2], res_final[1], res_final[0]};
            tuser_reg <= {fin.zw, ov_final};
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            vd_reg        <= {vd_reg[DIV_STEPS-2:0], v4_reg};
            out_valid_reg <= vd_reg[DIV_STEPS-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule
